// ===== rtl/cmd_pkg.sv =====
`default_nettype none

package cmd_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int SAMPLE_BITS = 16;

    localparam int X_BITS      = $clog2(MAX_WIDTH);
    localparam int Y_BITS      = $clog2(MAX_HEIGHT);
    // frame entry y*MAX_WIDTH+x: the row sits above the column bits
    localparam int ADDR_BITS   = X_BITS + Y_BITS;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // at most six taps of total weight eight, plus the rounding half
    localparam int ACC_BITS    = SAMPLE_BITS + 3;
    // scaled position plus signed origin plus tap offset
    localparam int COORD_BITS  = 13;

    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PC_BITS        = 4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SOURCE_WIDTH  = 3'd0,
        CFG_SOURCE_HEIGHT = 3'd1,
        CFG_SUBSAMPLE_X   = 3'd2,
        CFG_SUBSAMPLE_Y   = 3'd3,
        CFG_SITING        = 3'd4,
        CFG_ORIGIN_X      = 3'd5,
        CFG_ORIGIN_Y      = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_CONFIG   = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } t_status;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    localparam logic [1:0] SIT_CENTRE   = 2'd0;
    localparam logic [1:0] SIT_LEFT     = 2'd1;
    localparam logic [1:0] SIT_TOP_LEFT = 2'd2;

    typedef struct packed {
        logic                   operation;
        logic [7:0]             pos_x;
        logic [7:0]             pos_y;
        logic [15:0]            sample_in;
    } t_cmd;

    typedef struct packed {
        logic [15:0]            sample_out;
        t_status                status;
    } t_result;

    // microcode
    typedef enum logic [2:0] {
        UC_NEXT,
        UC_JUMP,
        UC_IF_WIDE,
        UC_IF_ONE_ROW,
        UC_DONE
    } t_ucond;

    typedef struct packed {
        logic                   rd;
        logic signed [2:0]      xoff;
        logic                   yoff;
        logic                   dbl;
        t_ucond                 cond;
        logic [PC_BITS-1:0]     target;
    } t_uword;

    typedef struct packed {
        logic                   wide;
        logic                   one_row;
    } t_uflags;

    typedef struct packed {
        logic                   active;
        logic                   rd;
        logic signed [2:0]      xoff;
        logic                   yoff;
        logic                   dbl;
        logic                   done;
    } t_uctl;

    localparam logic [PC_BITS-1:0] UA_POINT  = 4'd0;
    localparam logic [PC_BITS-1:0] UA_BOX    = 4'd1;
    localparam logic [PC_BITS-1:0] UA_BOX_W  = 4'd6;
    localparam logic [PC_BITS-1:0] UA_LEFT   = 4'd8;
    localparam logic [PC_BITS-1:0] UA_DRAIN  = 4'd14;
    localparam logic [PC_BITS-1:0] UA_FINISH = 4'd15;

    function automatic t_uword uw(input logic rd, input logic signed [2:0] xoff,
                                  input logic yoff, input logic dbl,
                                  input t_ucond cond, input logic [PC_BITS-1:0] target);
        t_uword w;
        w.rd     = rd;
        w.xoff   = xoff;
        w.yoff   = yoff;
        w.dbl    = dbl;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_uword ucode_rom(input logic [PC_BITS-1:0] addr);
        t_uword w;
        unique case (addr)
            // point sample
            4'd0:  w = uw(1'b1,  3'sd0, 1'b0, 1'b0, UC_JUMP,       UA_DRAIN);
            // box: two columns, then two more columns, a second row, or nothing more
            4'd1:  w = uw(1'b1,  3'sd0, 1'b0, 1'b0, UC_NEXT,       UA_DRAIN);
            4'd2:  w = uw(1'b1,  3'sd1, 1'b0, 1'b0, UC_IF_WIDE,    UA_BOX_W);
            4'd3:  w = uw(1'b0,  3'sd0, 1'b0, 1'b0, UC_IF_ONE_ROW, UA_DRAIN);
            4'd4:  w = uw(1'b1,  3'sd0, 1'b1, 1'b0, UC_NEXT,       UA_DRAIN);
            4'd5:  w = uw(1'b1,  3'sd1, 1'b1, 1'b0, UC_JUMP,       UA_DRAIN);
            4'd6:  w = uw(1'b1,  3'sd2, 1'b0, 1'b0, UC_NEXT,       UA_DRAIN);
            4'd7:  w = uw(1'b1,  3'sd3, 1'b0, 1'b0, UC_JUMP,       UA_DRAIN);
            // [1 2 1] over one or two rows
            4'd8:  w = uw(1'b1, -3'sd1, 1'b0, 1'b0, UC_NEXT,       UA_DRAIN);
            4'd9:  w = uw(1'b1,  3'sd0, 1'b0, 1'b1, UC_NEXT,       UA_DRAIN);
            4'd10: w = uw(1'b1,  3'sd1, 1'b0, 1'b0, UC_IF_ONE_ROW, UA_DRAIN);
            4'd11: w = uw(1'b1, -3'sd1, 1'b1, 1'b0, UC_NEXT,       UA_DRAIN);
            4'd12: w = uw(1'b1,  3'sd0, 1'b1, 1'b1, UC_NEXT,       UA_DRAIN);
            4'd13: w = uw(1'b1,  3'sd1, 1'b1, 1'b0, UC_NEXT,       UA_DRAIN);
            // last read data lands in the accumulator, then the result goes out
            4'd14: w = uw(1'b0,  3'sd0, 1'b0, 1'b0, UC_NEXT,       UA_FINISH);
            4'd15: w = uw(1'b0,  3'sd0, 1'b0, 1'b0, UC_DONE,       UA_FINISH);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cmd_sequencer.sv =====
`default_nettype none

module cmd_sequencer
    import cmd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_launch,
    input  wire logic [PC_BITS-1:0] i_entry,
    input  wire t_uflags            i_flags,
    output t_uctl                   o_ctl
);

    logic               r_active;
    logic               n_active;
    logic [PC_BITS-1:0] r_pc;
    logic [PC_BITS-1:0] n_pc;
    t_uword             word;
    logic               take_jump;

    assign word = ucode_rom(r_pc);

    always_comb begin
        unique case (word.cond)
            UC_JUMP:       take_jump = 1'b1;
            UC_IF_WIDE:    take_jump = i_flags.wide;
            UC_IF_ONE_ROW: take_jump = i_flags.one_row;
            default:       take_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (i_launch) begin
            n_pc     = i_entry;
            n_active = 1'b1;
        end else begin
            n_pc     = take_jump ? word.target : PC_BITS'(r_pc + 1'b1);
            n_active = r_active && (word.cond != UC_DONE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pc     <= UA_FINISH;
        end else begin
            r_active <= n_active;
            if (r_active || i_launch) begin
                r_pc <= n_pc;
            end
        end
    end

    always_comb begin
        o_ctl.active = r_active;
        o_ctl.rd     = r_active && word.rd;
        o_ctl.xoff   = word.xoff;
        o_ctl.yoff   = word.yoff;
        o_ctl.dbl    = word.dbl;
        o_ctl.done   = r_active && (word.cond == UC_DONE);
    end

endmodule

`default_nettype wire

// ===== rtl/chroma_mask_downsampler.sv =====
// chroma mask downsampler
// command channel: i_cmd is taken at a clock edge where start is high and busy
// is low. a store command writes one sample into the 256x256 frame memory; a
// compute command returns one filtered sample for a destination position.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at once;
// write only while no transaction is in flight.
// result channel: o_done is high for one cycle with o_result; it cannot be
// held off, so the receiver takes it in that cycle.
// timing: a store or a rejected command runs only the last closing step, and
// its result register is loaded there. a compute runs one microcode step per
// cycle: one step per frame read (1, 2, 4, 3 or 6 reads, plus one branch step
// for two-column boxes) and two closing steps, then the result is registered.
// the single-port frame memory allows one read per step.
// busy drops in the cycle o_done is shown, so a new command can follow then.
// reset clears the sequencer and loads the default configuration; the frame
// memory is not cleared and holds garbage until written.
`default_nettype none

module chroma_mask_downsampler
    import cmd_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire t_cmd                      i_cmd,
    input  wire logic                      i_cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    output logic                           o_done,
    output t_result                        o_result
);

    // configuration
    logic [8:0]        r_src_width;
    logic [8:0]        r_src_height;
    logic [2:0]        r_sub_x;
    logic [1:0]        r_sub_y;
    logic [1:0]        r_siting;
    logic signed [8:0] r_origin_x;
    logic signed [8:0] r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= 9'(MAX_WIDTH);
            r_src_height <= 9'(MAX_HEIGHT);
            r_sub_x      <= 3'd2;
            r_sub_y      <= 2'd2;
            r_siting     <= SIT_CENTRE;
            r_origin_x   <= '0;
            r_origin_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SOURCE_WIDTH:  r_src_width  <= i_cfg_data[8:0];
                CFG_SOURCE_HEIGHT: r_src_height <= i_cfg_data[8:0];
                CFG_SUBSAMPLE_X:   r_sub_x      <= i_cfg_data[2:0];
                CFG_SUBSAMPLE_Y:   r_sub_y      <= i_cfg_data[1:0];
                CFG_SITING:        r_siting     <= i_cfg_data[1:0];
                CFG_ORIGIN_X:      r_origin_x   <= $signed(i_cfg_data[8:0]);
                CFG_ORIGIN_Y:      r_origin_y   <= $signed(i_cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    logic cfg_ok;
    always_comb begin
        cfg_ok = 1'b1;
        if (r_src_width == '0 || r_src_width > 9'(MAX_WIDTH))      cfg_ok = 1'b0;
        if (r_src_height == '0 || r_src_height > 9'(MAX_HEIGHT))   cfg_ok = 1'b0;
        if (!(r_sub_x == 3'd1 || r_sub_x == 3'd2 || r_sub_x == 3'd4)) cfg_ok = 1'b0;
        if (!(r_sub_y == 2'd1 || r_sub_y == 2'd2))                 cfg_ok = 1'b0;
        if (r_sub_y == 2'd2 && r_sub_x != 3'd2)                    cfg_ok = 1'b0;
        if (r_siting > SIT_TOP_LEFT)                               cfg_ok = 1'b0;
    end

    // command decode
    logic               accept;
    logic               store_bad;
    logic               mode_point;
    logic               mode_box;
    logic [PC_BITS-1:0] entry;
    t_status            entry_status;
    logic [1:0]         entry_shift;
    logic               mem_we;
    t_uctl              ctl;
    t_uflags            flags;

    assign busy   = ctl.active;
    assign accept = start && !busy;

    assign store_bad  = ({1'b0, i_cmd.pos_x} >= r_src_width) ||
                        ({1'b0, i_cmd.pos_y} >= r_src_height);
    assign mode_point = (r_sub_x == 3'd1) || (r_siting == SIT_TOP_LEFT && r_sub_x != 3'd4);
    assign mode_box   = (r_sub_x == 3'd4) || (r_siting == SIT_CENTRE);

    always_comb begin
        entry        = UA_FINISH;
        entry_status = ST_OK;
        entry_shift  = 2'd0;
        if (!cfg_ok) begin
            entry_status = ST_BAD_CONFIG;
        end else if (i_cmd.operation == OP_STORE) begin
            if (store_bad) begin
                entry_status = ST_OUT_OF_RANGE;
            end
        end else if (mode_point) begin
            entry = UA_POINT;
        end else if (mode_box) begin
            entry       = UA_BOX;
            entry_shift = (r_sub_x == 3'd4 || r_sub_y == 2'd2) ? 2'd2 : 2'd1;
        end else begin
            entry       = UA_LEFT;
            entry_shift = (r_sub_y == 2'd2) ? 2'd3 : 2'd2;
        end
    end

    assign mem_we = accept && cfg_ok && (i_cmd.operation == OP_STORE) && !store_bad;

    assign flags.wide    = (r_sub_x == 3'd4);
    assign flags.one_row = (r_sub_y == 2'd1);

    cmd_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_launch (accept),
        .i_entry  (entry),
        .i_flags  (flags),
        .o_ctl    (ctl)
    );

    // source base position
    logic [COORD_BITS-2:0]   prod_x;
    logic [COORD_BITS-2:0]   prod_y;
    logic signed [COORD_BITS-1:0] r_sx;
    logic signed [COORD_BITS-1:0] r_sy;
    logic                    r_is_compute;
    t_status                 r_status;
    logic [1:0]              r_shift;

    assign prod_x = (COORD_BITS-1)'(i_cmd.pos_x) * (COORD_BITS-1)'(r_sub_x);
    assign prod_y = (COORD_BITS-1)'(i_cmd.pos_y) * (COORD_BITS-1)'(r_sub_y);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sx         <= $signed({1'b0, prod_x}) + COORD_BITS'(r_origin_x);
            r_sy         <= $signed({1'b0, prod_y}) + COORD_BITS'(r_origin_y);
            r_is_compute <= cfg_ok && (i_cmd.operation == OP_COMPUTE);
            r_status     <= entry_status;
            r_shift      <= entry_shift;
        end
    end

    // tap position, clamped to the source edges
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] w_lim;
    logic signed [COORD_BITS-1:0] h_lim;
    logic [X_BITS-1:0]            cx;
    logic [Y_BITS-1:0]            cy;

    assign px    = r_sx + COORD_BITS'(ctl.xoff);
    assign py    = r_sy + $signed({{(COORD_BITS-1){1'b0}}, ctl.yoff});
    assign w_lim = $signed(COORD_BITS'(r_src_width));
    assign h_lim = $signed(COORD_BITS'(r_src_height));

    always_comb begin
        if (px < 0) begin
            cx = '0;
        end else if (px >= w_lim) begin
            cx = X_BITS'(r_src_width - 9'd1);
        end else begin
            cx = X_BITS'(px);
        end
        if (py < 0) begin
            cy = '0;
        end else if (py >= h_lim) begin
            cy = Y_BITS'(r_src_height - 9'd1);
        end else begin
            cy = Y_BITS'(py);
        end
    end

    // frame memory, one port
    logic [SAMPLE_BITS-1:0] r_mem [0:STORE_DEPTH-1];
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic [ADDR_BITS-1:0]   mem_addr;

    assign mem_addr = accept ? {Y_BITS'(i_cmd.pos_y), X_BITS'(i_cmd.pos_x)} : {cy, cx};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= i_cmd.sample_in[SAMPLE_BITS-1:0];
        end
        r_rdata <= r_mem[mem_addr];
    end

    // accumulate taps in the cycle after each read
    logic                r_rd_pend;
    logic                r_rd_dbl;
    logic [ACC_BITS-1:0] r_acc;
    logic [ACC_BITS-1:0] tap;

    assign tap = r_rd_dbl ? ACC_BITS'({r_rdata, 1'b0}) : ACC_BITS'(r_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= ctl.rd;
        end
        r_rd_dbl <= ctl.dbl;
        if (accept) begin
            r_acc <= '0;
        end else if (r_rd_pend) begin
            r_acc <= r_acc + tap;
        end
    end

    // round half up, divisor is a power of two
    logic [ACC_BITS-1:0] half;
    logic [ACC_BITS-1:0] rsum;
    logic [ACC_BITS-1:0] rounded;

    always_comb begin
        case (r_shift)
            2'd0:    half = ACC_BITS'(0);
            2'd1:    half = ACC_BITS'(1);
            2'd2:    half = ACC_BITS'(2);
            default: half = ACC_BITS'(4);
        endcase
    end

    assign rsum    = r_acc + half;
    assign rounded = rsum >> r_shift;

    // result register
    logic                   r_done;
    logic [SAMPLE_BITS-1:0] r_out_sample;
    t_status                r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ctl.done;
        end
        if (ctl.done) begin
            r_out_sample <= r_is_compute ? rounded[SAMPLE_BITS-1:0] : '0;
            r_out_status <= r_status;
        end
    end

    assign o_done              = r_done;
    assign o_result.sample_out = 16'(r_out_sample);
    assign o_result.status     = r_out_status;

endmodule

`default_nettype wire

// ===== rtl/cmd_checker.sv =====
`default_nettype none

module cmd_checker
    import cmd_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_done,
    input wire t_result o_result
);

    // a taken transaction keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after a transaction was taken");

    // the result shows exactly when busy drops
    a_done_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("busy dropped without a result");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_OK |-> o_result.sample_out == '0)
        else $error("nonzero sample with an error status");

endmodule

bind chroma_mask_downsampler cmd_checker u_cmd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

`default_nettype wire
